// File: hw/rtl/lrbf_pkg.sv
// ----------------------------------------------------------------------------
// lrbf_pkg
// Shared types, constants and the crc32c byte update for the log record
// block framer.
// ----------------------------------------------------------------------------
package lrbf_pkg;

  localparam int BLOCK_BYTES  = 32768;
  localparam int HEADER_BYTES = 7;

  // internal positions must hold BLOCK_BYTES itself
  localparam int POS_W     = $clog2(BLOCK_BYTES + 1);
  localparam int OUT_POS_W = 15;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MASK_DELTA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FULL_TYPE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_TYPE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MID_TYPE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST_TYPE  = 3'd4;

  localparam logic [31:0] MASK_DELTA_RST = 32'hA282_EAD8;
  localparam logic [7:0]  FULL_TYPE_RST  = 8'd1;
  localparam logic [7:0]  FIRST_TYPE_RST = 8'd2;
  localparam logic [7:0]  MID_TYPE_RST   = 8'd3;
  localparam logic [7:0]  LAST_TYPE_RST  = 8'd4;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_HDR  = 2'd1,
    KIND_PAD  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       record_end;
  } in_word_t;

  typedef struct packed {
    kind_t                out_kind;
    logic [OUT_POS_W-1:0] block_position;
    logic [7:0]           data_byte;
    logic [31:0]          header_checksum;
    logic [OUT_POS_W-1:0] header_length;
    logic [7:0]           header_type;
    logic [2:0]           pad_count;
    logic                 last_of_run;
  } out_word_t;

  // configuration, with the crc state after each type byte kept alongside
  typedef struct packed {
    logic [31:0] mask_delta;
    logic [7:0]  full_code;
    logic [7:0]  first_code;
    logic [7:0]  mid_code;
    logic [7:0]  last_code;
    logic [31:0] full_seed;
    logic [31:0] first_seed;
    logic [31:0] mid_seed;
    logic [31:0] last_seed;
  } cfg_t;

  // one queued job: a data byte and what the fragment close emits after it
  typedef struct packed {
    logic [7:0]           data_byte;
    logic [OUT_POS_W-1:0] data_pos;
    logic                 close;
    logic [31:0]          crc;
    logic [OUT_POS_W-1:0] hdr_pos;
    logic [OUT_POS_W-1:0] hdr_len;
    logic [7:0]           hdr_type;
    logic                 pad;
    logic [OUT_POS_W-1:0] pad_pos;
    logic [2:0]           pad_count;
  } job_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/lrbf_cfg.sv
// ----------------------------------------------------------------------------
// lrbf_cfg
// Configuration registers, with crc seeds derived from the type codes as
// they are written.
// ----------------------------------------------------------------------------
module lrbf_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [lrbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrbf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lrbf_pkg::cfg_t                 cfg_o
);

  lrbf_pkg::cfg_t cfg_r;
  logic [31:0]    seed_w;

  assign seed_w = lrbf_pkg::crc_byte(lrbf_pkg::CRC_INIT, cfg_wdata[7:0]);
  assign cfg_o  = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mask_delta <= lrbf_pkg::MASK_DELTA_RST;
      cfg_r.full_code  <= lrbf_pkg::FULL_TYPE_RST;
      cfg_r.first_code <= lrbf_pkg::FIRST_TYPE_RST;
      cfg_r.mid_code   <= lrbf_pkg::MID_TYPE_RST;
      cfg_r.last_code  <= lrbf_pkg::LAST_TYPE_RST;
      cfg_r.full_seed  <= lrbf_pkg::crc_byte(lrbf_pkg::CRC_INIT, lrbf_pkg::FULL_TYPE_RST);
      cfg_r.first_seed <= lrbf_pkg::crc_byte(lrbf_pkg::CRC_INIT, lrbf_pkg::FIRST_TYPE_RST);
      cfg_r.mid_seed   <= lrbf_pkg::crc_byte(lrbf_pkg::CRC_INIT, lrbf_pkg::MID_TYPE_RST);
      cfg_r.last_seed  <= lrbf_pkg::crc_byte(lrbf_pkg::CRC_INIT, lrbf_pkg::LAST_TYPE_RST);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lrbf_pkg::CFG_IDX_MASK_DELTA: begin
          cfg_r.mask_delta <= cfg_wdata;
        end
        lrbf_pkg::CFG_IDX_FULL_TYPE: begin
          cfg_r.full_code <= cfg_wdata[7:0];
          cfg_r.full_seed <= seed_w;
        end
        lrbf_pkg::CFG_IDX_FIRST_TYPE: begin
          cfg_r.first_code <= cfg_wdata[7:0];
          cfg_r.first_seed <= seed_w;
        end
        lrbf_pkg::CFG_IDX_MID_TYPE: begin
          cfg_r.mid_code <= cfg_wdata[7:0];
          cfg_r.mid_seed <= seed_w;
        end
        lrbf_pkg::CFG_IDX_LAST_TYPE: begin
          cfg_r.last_code <= cfg_wdata[7:0];
          cfg_r.last_seed <= seed_w;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/lrbf_front.sv
// ----------------------------------------------------------------------------
// lrbf_front
// Takes payload words, tracks block and fragment positions, runs both crc
// candidates and queues one job per word.
// ----------------------------------------------------------------------------
module lrbf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  lrbf_pkg::cfg_t     cfg_i,
  input  logic               in_valid,
  output logic               in_ready,
  input  lrbf_pkg::in_word_t in_data,
  input  logic               q_full,
  output logic               q_push,
  output lrbf_pkg::job_t     q_job
);

  localparam int PW = lrbf_pkg::POS_W;
  localparam logic [PW-1:0] BLOCK_LIM = PW'(lrbf_pkg::BLOCK_BYTES);
  localparam logic [PW-1:0] HDR_LEN   = PW'(lrbf_pkg::HEADER_BYTES);

  logic [PW-1:0] block_fill_r, block_fill_nxt;
  logic [PW-1:0] frag_start_r, frag_start_nxt;
  logic [PW-1:0] data_pos_r, data_pos_nxt;
  logic [PW-1:0] frag_cnt_r, frag_cnt_nxt;
  logic [31:0]   run_crc_r, run_crc_nxt;
  logic [31:0]   alt_crc_r, alt_crc_nxt;
  logic [7:0]    end_code_r, end_code_nxt;
  logic [7:0]    alt_code_r, alt_code_nxt;
  logic          at_begin_r, at_begin_nxt;
  logic          open_r, open_nxt;

  logic          accept;
  logic [PW-1:0] pos_end, leftover;
  logic          close, tail_short;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  always_comb begin
    logic [31:0] run_base, alt_base;
    if (open_r) begin
      frag_start_nxt = frag_start_r;
      data_pos_nxt   = data_pos_r;
      frag_cnt_nxt   = frag_cnt_r;
      end_code_nxt   = end_code_r;
      alt_code_nxt   = alt_code_r;
      run_base       = run_crc_r;
      alt_base       = alt_crc_r;
    end else begin
      frag_start_nxt = block_fill_r;
      data_pos_nxt   = block_fill_r + HDR_LEN;
      frag_cnt_nxt   = '0;
      end_code_nxt   = at_begin_r ? cfg_i.full_code  : cfg_i.last_code;
      alt_code_nxt   = at_begin_r ? cfg_i.first_code : cfg_i.mid_code;
      run_base       = at_begin_r ? cfg_i.full_seed  : cfg_i.last_seed;
      alt_base       = at_begin_r ? cfg_i.first_seed : cfg_i.mid_seed;
    end

    run_crc_nxt = lrbf_pkg::crc_byte(run_base, in_data.payload_byte);
    alt_crc_nxt = lrbf_pkg::crc_byte(alt_base, in_data.payload_byte);

    q_job.data_byte = in_data.payload_byte;
    q_job.data_pos  = data_pos_nxt[lrbf_pkg::OUT_POS_W-1:0];

    pos_end    = data_pos_nxt + PW'(1);
    frag_cnt_nxt = frag_cnt_nxt + PW'(1);
    close      = in_data.record_end || (pos_end >= BLOCK_LIM);
    leftover   = BLOCK_LIM - pos_end;
    tail_short = leftover <= HDR_LEN;

    q_job.close     = close;
    q_job.crc       = (in_data.record_end ? run_crc_nxt : alt_crc_nxt) ^ lrbf_pkg::CRC_INIT;
    q_job.hdr_pos   = frag_start_nxt[lrbf_pkg::OUT_POS_W-1:0];
    q_job.hdr_len   = frag_cnt_nxt[lrbf_pkg::OUT_POS_W-1:0];
    q_job.hdr_type  = in_data.record_end ? end_code_nxt : alt_code_nxt;
    q_job.pad       = close && tail_short && (leftover != '0);
    q_job.pad_pos   = pos_end[lrbf_pkg::OUT_POS_W-1:0];
    q_job.pad_count = leftover[2:0];

    block_fill_nxt = block_fill_r;
    at_begin_nxt   = at_begin_r;
    open_nxt       = !close;
    if (close) begin
      block_fill_nxt = tail_short ? '0 : pos_end;
      at_begin_nxt   = in_data.record_end;
    end
    data_pos_nxt = pos_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_fill_r <= '0;
      at_begin_r   <= 1'b1;
      open_r       <= 1'b0;
    end else if (accept) begin
      block_fill_r <= block_fill_nxt;
      at_begin_r   <= at_begin_nxt;
      open_r       <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frag_start_r <= frag_start_nxt;
      data_pos_r   <= data_pos_nxt;
      frag_cnt_r   <= frag_cnt_nxt;
      run_crc_r    <= run_crc_nxt;
      alt_crc_r    <= alt_crc_nxt;
      end_code_r   <= end_code_nxt;
      alt_code_r   <= alt_code_nxt;
    end
  end

endmodule

// File: hw/rtl/lrbf_fifo.sv
// ----------------------------------------------------------------------------
// lrbf_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module lrbf_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lrbf_pkg::job_t push_job,
  input  logic           pop,
  output lrbf_pkg::job_t head_job,
  output logic           full,
  output logic           empty
);

  localparam int AW = lrbf_pkg::FIFO_AW;
  localparam logic [AW:0] DEPTH = (AW+1)'(lrbf_pkg::FIFO_DEPTH);

  lrbf_pkg::job_t mem [lrbf_pkg::FIFO_DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [AW:0]    count_r;

  assign full     = count_r == DEPTH;
  assign empty    = count_r == '0;
  assign head_job = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (AW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (AW+1)'(1);
      end
    end
  end

endmodule

// File: hw/rtl/lrbf_back.sv
// ----------------------------------------------------------------------------
// lrbf_back
// Expands each queued job into its data, header and padding words and
// drives the registered result channel.
// ----------------------------------------------------------------------------
module lrbf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lrbf_pkg::cfg_t      cfg_i,
  input  lrbf_pkg::job_t      head_job,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lrbf_pkg::out_word_t out_data
);

  typedef enum logic [1:0] {
    PH_DATA,
    PH_HDR,
    PH_PAD
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic                out_valid_r, out_valid_nxt;
  lrbf_pkg::out_word_t out_r, out_nxt;
  logic                load;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign load      = !out_valid_r || out_ready;

  always_comb begin
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    if (load && !q_empty) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      unique case (phase_r)
        PH_DATA: begin
          out_nxt.out_kind       = lrbf_pkg::KIND_DATA;
          out_nxt.block_position = head_job.data_pos;
          out_nxt.data_byte      = head_job.data_byte;
          out_nxt.last_of_run    = !head_job.close;
          q_pop                  = !head_job.close;
          phase_nxt              = head_job.close ? PH_HDR : PH_DATA;
        end
        PH_HDR: begin
          out_nxt.out_kind        = lrbf_pkg::KIND_HDR;
          out_nxt.block_position  = head_job.hdr_pos;
          // rotate right by 15 then add the delta
          out_nxt.header_checksum = {head_job.crc[14:0], head_job.crc[31:15]}
                                    + cfg_i.mask_delta;
          out_nxt.header_length   = head_job.hdr_len;
          out_nxt.header_type     = head_job.hdr_type;
          out_nxt.last_of_run     = !head_job.pad;
          q_pop                   = !head_job.pad;
          phase_nxt               = head_job.pad ? PH_PAD : PH_DATA;
        end
        PH_PAD: begin
          out_nxt.out_kind       = lrbf_pkg::KIND_PAD;
          out_nxt.block_position = head_job.pad_pos;
          out_nxt.pad_count      = head_job.pad_count;
          out_nxt.last_of_run    = 1'b1;
          q_pop                  = 1'b1;
          phase_nxt              = PH_DATA;
        end
        default: begin
          phase_nxt = PH_DATA;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DATA;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

endmodule

// File: hw/rtl/log_record_block_framer_top.sv
// ----------------------------------------------------------------------------
// log_record_block_framer_top
// Frames record payload bytes into fixed blocks of fragments with masked
// crc32c headers and tail padding.
// ----------------------------------------------------------------------------
//  channel  | ports                              | moves
//  ---------+------------------------------------+------------------------------
//  input    | in_valid, in_ready, in_data        | one payload byte and end flag
//  result   | out_valid, out_ready, out_data     | data, header or padding word
//  config   | cfg_wr_en, cfg_index, cfg_wdata    | one register write, no wait
//
// each input word yields 1 to 3 result words: data, a header when it closes
// a fragment, then padding; one result word goes out per cycle while
// out_ready is high. input words are taken every cycle while the 4-entry job
// queue has room and pass through it to the registered output. reset is
// synchronous and needs no clearing pass. either side may stall alone.
// ----------------------------------------------------------------------------
module log_record_block_framer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lrbf_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lrbf_pkg::out_word_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [lrbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrbf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  lrbf_pkg::cfg_t cfg;
  lrbf_pkg::job_t push_job, head_job;
  logic           q_push, q_pop, q_full, q_empty;

  lrbf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  lrbf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  lrbf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  lrbf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .head_job  (head_job),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: dv/tb_log_record_block_framer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_log_record_block_framer_top
// Self-checking bench for the log record block framer. Record bytes go in
// with random gaps, and the bench predicts every data, header and padding
// word. Each result word is compared field by field while the result side
// stalls at random. The runs cover short and longer records and type codes.
// ----------------------------------------------------------------------------
module tb_log_record_block_framer_top;

  localparam int          QUIET_LIMIT   = 1000;
  localparam int          TAIL_CYCLES   = 8;
  localparam int          PRINT_CAP     = 40;
  localparam logic [31:0] CRC32C_POLY_R = 32'h82F6_3B78;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  lrbf_pkg::in_word_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  lrbf_pkg::out_word_t             out_data;
  logic                            cfg_wr_en = 1'b0;
  logic [lrbf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lrbf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // register copies
  logic [31:0] mask_add;
  logic [7:0]  code_full, code_first, code_mid, code_last;

  // framing state copies
  int unsigned blk_fill, frag_start, frag_len;
  logic [31:0] crc_end, crc_alt;
  logic [7:0]  open_end_code, open_alt_code;
  bit          rec_begin, frag_open;

  lrbf_pkg::out_word_t expected_words[$];
  int          mismatches     = 0;
  int          words_checked  = 0;
  bit          in_idle_on     = 1'b1;
  bit          out_idle_on    = 1'b1;
  int          out_stall_left = 0;

  log_record_block_framer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] crc32c_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    r = acc ^ {24'd0, b};
    repeat (8) r = (r >> 1) ^ (r[0] ? CRC32C_POLY_R : 32'd0);
    return r;
  endfunction

  function automatic lrbf_pkg::out_word_t make_word(input lrbf_pkg::kind_t kind,
                                                    input int unsigned pos);
    lrbf_pkg::out_word_t w;
    w = '0;
    w.out_kind = kind;
    w.block_position = pos[lrbf_pkg::OUT_POS_W-1:0];
    return w;
  endfunction

  // expected words for one accepted byte
  function automatic void frame_byte(input lrbf_pkg::in_word_t w);
    lrbf_pkg::out_word_t run[$];
    lrbf_pkg::out_word_t r;
    int unsigned avail, leftover;
    logic [31:0] crc;
    if (!frag_open) begin
      frag_start = blk_fill;
      frag_len = 0;
      // type codes are latched here for the whole fragment
      open_end_code = rec_begin ? code_full : code_last;
      open_alt_code = rec_begin ? code_first : code_mid;
      crc_end = crc32c_step(32'hFFFF_FFFF, open_end_code);
      crc_alt = crc32c_step(32'hFFFF_FFFF, open_alt_code);
      frag_open = 1'b1;
    end
    r = make_word(lrbf_pkg::KIND_DATA, frag_start + lrbf_pkg::HEADER_BYTES + frag_len);
    r.data_byte = w.payload_byte;
    run.push_back(r);
    crc_end = crc32c_step(crc_end, w.payload_byte);
    crc_alt = crc32c_step(crc_alt, w.payload_byte);
    frag_len++;
    avail = lrbf_pkg::BLOCK_BYTES - frag_start - lrbf_pkg::HEADER_BYTES;
    if (w.record_end || frag_len >= avail) begin
      crc = (w.record_end ? crc_end : crc_alt) ^ 32'hFFFF_FFFF;
      r = make_word(lrbf_pkg::KIND_HDR, frag_start);
      r.header_checksum = {crc[14:0], crc[31:15]} + mask_add;
      r.header_length = frag_len[lrbf_pkg::OUT_POS_W-1:0];
      r.header_type = w.record_end ? open_end_code : open_alt_code;
      run.push_back(r);
      blk_fill = frag_start + lrbf_pkg::HEADER_BYTES + frag_len;
      leftover = lrbf_pkg::BLOCK_BYTES - blk_fill;
      // a tail too short for a header is padded, an exact fill is not
      if (leftover <= lrbf_pkg::HEADER_BYTES) begin
        if (leftover > 0) begin
          r = make_word(lrbf_pkg::KIND_PAD, blk_fill);
          r.pad_count = leftover[2:0];
          run.push_back(r);
        end
        blk_fill = 0;
      end
      rec_begin = w.record_end;
      frag_open = 1'b0;
      frag_len = 0;
    end
    run[run.size()-1].last_of_run = 1'b1;
    foreach (run[i]) expected_words.push_back(run[i]);
  endfunction

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] pick_delta();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    // keep the log short when something goes badly wrong
    if (mismatches < PRINT_CAP)
      $display("%0t: result word %0d: %s got 0x%0h, expected 0x%0h",
               $time, words_checked, what, got, want);
    mismatches++;
  endtask

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input logic [7:0] b, input logic is_end);
    lrbf_pkg::in_word_t w;
    bit       taken;
    w.payload_byte = b;
    w.record_end = is_end;
    if (in_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    frame_byte(w);
  endtask

  task automatic send_record(input int unsigned len);
    for (int unsigned i = 1; i <= len; i++) send_word(8'($urandom_range(0, 255)), i == len);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lrbf_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      lrbf_pkg::CFG_IDX_MASK_DELTA: mask_add   = val;
      lrbf_pkg::CFG_IDX_FULL_TYPE:  code_full  = val[7:0];
      lrbf_pkg::CFG_IDX_FIRST_TYPE: code_first = val[7:0];
      lrbf_pkg::CFG_IDX_MID_TYPE:   code_mid   = val[7:0];
      lrbf_pkg::CFG_IDX_LAST_TYPE:  code_last  = val[7:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] delta, input logic [7:0] c_full,
                           input logic [7:0] c_first, input logic [7:0] c_mid,
                           input logic [7:0] c_last);
    write_reg(lrbf_pkg::CFG_IDX_MASK_DELTA, delta);
    write_reg(lrbf_pkg::CFG_IDX_FULL_TYPE, {24'd0, c_full});
    write_reg(lrbf_pkg::CFG_IDX_FIRST_TYPE, {24'd0, c_first});
    write_reg(lrbf_pkg::CFG_IDX_MID_TYPE, {24'd0, c_mid});
    write_reg(lrbf_pkg::CFG_IDX_LAST_TYPE, {24'd0, c_last});
  endtask

  task automatic test_short_records();
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h55, 1'b0);
    send_word(8'hAA, 1'b1);
    send_word(8'h31, 1'b0);
    send_word(8'h32, 1'b1);
    drain();
  endtask

  task automatic test_register_extremes();
    write_all(32'h0000_0000, 8'h00, 8'hFF, 8'h00, 8'hFF);
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h80, 1'b1);
    drain();
    write_all(32'hFFFF_FFFF, 8'hFF, 8'h00, 8'hFF, 8'h00);
    send_word(8'h01, 1'b1);
    send_record(3);
    drain();
  endtask

  task automatic test_code_latching();
    write_all(lrbf_pkg::MASK_DELTA_RST, lrbf_pkg::FULL_TYPE_RST, lrbf_pkg::FIRST_TYPE_RST,
              lrbf_pkg::MID_TYPE_RST, lrbf_pkg::LAST_TYPE_RST);
    send_word(8'h10, 1'b0);
    send_word(8'h20, 1'b0);
    drain();
    // new codes wait for the next fragment, the new delta applies at this close
    write_all(32'h1234_5678, 8'h11, 8'h22, 8'h33, 8'h44);
    send_word(8'h30, 1'b1);
    send_word(8'h40, 1'b1);
    drain();
  endtask

  task automatic test_random_records(input int unsigned n_words);
    int unsigned sent, len;
    sent = 0;
    write_all(pick_delta(), pick_code(), pick_code(), pick_code(), pick_code());
    while (sent < n_words) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      send_record(len);
      sent += len;
    end
    drain();
  endtask

  // result side stalls in short bursts
  always @(posedge clk) begin
    if (out_stall_left > 0) begin
      out_ready <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      out_stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // sampled mid-cycle, so it sees what the next rising edge takes
  always @(negedge clk) begin : check_results
    lrbf_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with none expected, out_kind", 32'(out_data.out_kind), '0);
      end else begin
        want = expected_words.pop_front();
        if (out_data.out_kind !== want.out_kind)
          report_mismatch("out_kind", 32'(out_data.out_kind), 32'(want.out_kind));
        if (out_data.block_position !== want.block_position)
          report_mismatch("block_position", 32'(out_data.block_position),
                          32'(want.block_position));
        if (out_data.data_byte !== want.data_byte)
          report_mismatch("data_byte", 32'(out_data.data_byte), 32'(want.data_byte));
        if (out_data.header_checksum !== want.header_checksum)
          report_mismatch("header_checksum", out_data.header_checksum, want.header_checksum);
        if (out_data.header_length !== want.header_length)
          report_mismatch("header_length", 32'(out_data.header_length),
                          32'(want.header_length));
        if (out_data.header_type !== want.header_type)
          report_mismatch("header_type", 32'(out_data.header_type), 32'(want.header_type));
        if (out_data.pad_count !== want.pad_count)
          report_mismatch("pad_count", 32'(out_data.pad_count), 32'(want.pad_count));
        if (out_data.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", 32'(out_data.last_of_run), 32'(want.last_of_run));
      end
      words_checked++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    mask_add   = lrbf_pkg::MASK_DELTA_RST;
    code_full  = lrbf_pkg::FULL_TYPE_RST;
    code_first = lrbf_pkg::FIRST_TYPE_RST;
    code_mid   = lrbf_pkg::MID_TYPE_RST;
    code_last  = lrbf_pkg::LAST_TYPE_RST;
    blk_fill   = 0;
    frag_start = 0;
    frag_len   = 0;
    crc_end    = 32'hFFFF_FFFF;
    crc_alt    = 32'hFFFF_FFFF;
    open_end_code = '0;
    open_alt_code = '0;
    rec_begin  = 1'b1;
    frag_open  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_records();
    test_register_extremes();
    test_code_latching();
    test_random_records(110);
    test_random_records(110);
    // last stretch at full rate on both sides
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    test_random_records(100);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
